### rtl/srsl_pkg.sv
// ----------------------------------------------------------------------------
// srsl_pkg: shared types and constants of the sorted range-start lookup
// Holds the item and result layouts, the command format passed from the
// front to the back, and the state encoding of the search engine.
// ----------------------------------------------------------------------------
package srsl_pkg;

  localparam int unsigned SlotW  = 10;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned CountW = 11;

  localparam logic [CountW-1:0] CountReset = 11'd1;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [SlotW-1:0] entry_index;
    logic [AddrW-1:0] start_address;
    logic [AddrW-1:0] record_offset;
    logic [AddrW-1:0] lookup_address;
  } item_t;

  typedef struct packed {
    logic [SlotW-1:0] found_index;
    logic [AddrW-1:0] found_offset;
    logic [AddrW-1:0] found_start;
  } result_t;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SKIP   = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_op_e;

  // For a search, addr carries the key; for a write, the range start.
  typedef struct packed {
    cmd_op_e          op;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] offset;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PROBE = 2'd1,
    ST_FETCH = 2'd2
  } back_state_e;

endpackage

### rtl/sorted_range_start_lookup.sv
// ----------------------------------------------------------------------------
// sorted_range_start_lookup: binary search over a table of range starts
// Top level tying the intake front, the search engine and the result queue.
// ----------------------------------------------------------------------------
// Items enter through a queue-style port: an item transfers on a clock edge
// with push high and full low. A load item writes one table entry and gives
// no result; a lookup item gives one result. Results leave the same way: the
// oldest result sits on result_o while empty is low and transfers on an edge
// with pop high. Results come out in item order.
// The entry count register is written through its own valid/ready channel;
// ready is always high. A count of zero reads as one and a count above the
// table depth reads as the depth. Write it only while the block is idle.
// The engine writes a load as it takes it from the front. A lookup issues
// one probe per cycle (ceil(log2(count)) probes, 10 at a full table of 1024)
// and then hands over the settled entry. The single read port of the table
// memory sets the probe rate. A new command is taken only while idle.
// Two commands queue ahead of the engine and two results behind it, so a
// stalled receiver backs up into full only after both queues fill.
// Reset empties both queues, idles the engine and sets the count to one;
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_range_start_lookup import srsl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  item_t             item_i,
  input  logic              push,
  output logic              full,
  output result_t           result_o,
  output logic              empty,
  input  logic              pop,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH) + 1;

  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     cfg_wide;
  logic [31:0]     cfg_clamped;

  cmd_t            cmd;
  logic            cmd_valid;
  logic            cmd_pop;
  result_t         res;
  logic            res_push;
  logic            res_full;

  // The count is stored already clamped so the search sees a legal bound.
  assign cfg_ready_o = 1'b1;
  assign cfg_wide    = 32'(cfg_data_i);

  always_comb begin
    if (cfg_wide == 32'd0) begin
      cfg_clamped = 32'd1;
    end else if (cfg_wide > 32'(TABLE_DEPTH)) begin
      cfg_clamped = 32'(TABLE_DEPTH);
    end else begin
      cfg_clamped = cfg_wide;
    end
    count_d = (cfg_valid_i && cfg_ready_o) ? cfg_clamped[CntW-1:0] : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(CountReset);
    end else begin
      count_q <= count_d;
    end
  end

  // The front decodes items and buffers them so that intake continues while
  // a search is under way.
  srsl_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .push_i     (push),
    .full_o     (full),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop)
  );

  srsl_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .count_i    (count_q),
    .res_o      (res),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  srsl_out_q u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .push_i (res_push),
    .full_o (res_full),
    .res_o  (result_o),
    .empty_o(empty),
    .pop_i  (pop)
  );

endmodule

### rtl/srsl_front.sv
// ----------------------------------------------------------------------------
// srsl_front: item intake and classification
// Decodes each incoming item into a command and holds up to two commands
// for the search engine.
// ----------------------------------------------------------------------------
module srsl_front import srsl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t item_i,
  input  logic  push_i,
  output logic  full_o,
  output cmd_t  cmd_o,
  output logic  cmd_valid_o,
  input  logic  cmd_pop_i
);

  cmd_t       cmd_in;
  cmd_t       slots_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push_ok;
  logic       pop_ok;

  // Loads aimed past the end of the table are kept in order but write nothing.
  always_comb begin
    cmd_in.slot   = item_i.entry_index;
    cmd_in.offset = item_i.record_offset;
    if (item_i.opcode == OpLookup) begin
      cmd_in.op   = CMD_SEARCH;
      cmd_in.addr = item_i.lookup_address;
    end else begin
      cmd_in.op   = (32'(item_i.entry_index) < 32'(TABLE_DEPTH)) ? CMD_WRITE : CMD_SKIP;
      cmd_in.addr = item_i.start_address;
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slots_q[rd_ptr_q];
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_ok) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slots_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### rtl/srsl_back.sv
// ----------------------------------------------------------------------------
// srsl_back: table storage and binary search engine
// Owns both tables, applies writes in order and runs one probe per cycle
// for each search, then reads the settled entry.
// ----------------------------------------------------------------------------
module srsl_back import srsl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cmd_t                             cmd_i,
  input  logic                             cmd_valid_i,
  output logic                             cmd_pop_o,
  input  logic [$clog2(TABLE_DEPTH):0]     count_i,
  output result_t                          res_o,
  output logic                             res_push_o,
  input  logic                             res_full_i
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned ExtW = IdxW + SlotW;

  logic [AddrW-1:0] start_mem  [TABLE_DEPTH];
  logic [AddrW-1:0] offset_mem [TABLE_DEPTH];
  logic [AddrW-1:0] start_rd_q;
  logic [AddrW-1:0] offset_rd_q;

  back_state_e      state_q, state_d;
  logic [CntW-1:0]  lo_q, lo_d;
  logic [CntW-1:0]  hi_q, hi_d;
  logic [CntW-1:0]  mid_q, mid_d;
  logic [AddrW-1:0] key_q, key_d;

  logic             start_search;
  logic             go_left;
  logic [CntW-1:0]  base_lo;
  logic [CntW-1:0]  base_hi;
  logic [CntW:0]    span_sum;
  logic             more;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic             wr_en;
  logic [ExtW-1:0]  slot_ext;
  logic [ExtW-1:0]  lo_ext;

  assign start_search = cmd_valid_i && (cmd_i.op == CMD_SEARCH);
  assign go_left      = key_q < start_rd_q;

  // Bounds for the next probe: the full range at the start of a search,
  // otherwise the range narrowed by the probe that just returned.
  always_comb begin
    if (state_q == ST_PROBE) begin
      base_lo = go_left ? lo_q : mid_q;
      base_hi = go_left ? mid_q : hi_q;
    end else begin
      base_lo = '0;
      base_hi = count_i;
    end
    span_sum = {1'b0, base_lo} + {1'b0, base_hi};
    more     = ({1'b0, base_lo} + (CntW + 1)'(1)) < {1'b0, base_hi};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_search) begin
          state_d = more ? ST_PROBE : ST_FETCH;
        end
      end
      ST_PROBE: state_d = more ? ST_PROBE : ST_FETCH;
      ST_FETCH: begin
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    res_push_o = 1'b0;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    key_d      = key_q;
    rd_addr    = more ? span_sum[IdxW:1] : base_lo[IdxW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        wr_en     = cmd_valid_i && (cmd_i.op == CMD_WRITE);
        if (start_search) begin
          rd_en = 1'b1;
          key_d = cmd_i.addr;
          lo_d  = base_lo;
          hi_d  = base_hi;
          mid_d = span_sum[CntW:1];
        end
      end
      ST_PROBE: begin
        rd_en = 1'b1;
        lo_d  = base_lo;
        hi_d  = base_hi;
        mid_d = span_sum[CntW:1];
      end
      ST_FETCH: res_push_o = !res_full_i;
      default: ;
    endcase
  end

  assign slot_ext = ExtW'(cmd_i.slot);
  assign lo_ext   = ExtW'(lo_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[slot_ext[IdxW-1:0]]  <= cmd_i.addr;
      offset_mem[slot_ext[IdxW-1:0]] <= cmd_i.offset;
    end
    if (rd_en) begin
      start_rd_q  <= start_mem[rd_addr];
      offset_rd_q <= offset_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
  end

  assign res_o.found_index  = lo_ext[SlotW-1:0];
  assign res_o.found_offset = offset_rd_q;
  assign res_o.found_start  = start_rd_q;

endmodule

### rtl/srsl_out_q.sv
// ----------------------------------------------------------------------------
// srsl_out_q: result queue
// Two-entry queue that lets the search engine finish while the receiver
// holds off the previous result.
// ----------------------------------------------------------------------------
module srsl_out_q import srsl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  result_t res_i,
  input  logic    push_i,
  output logic    full_o,
  output result_t res_o,
  output logic    empty_o,
  input  logic    pop_i
);

  result_t    slots_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push_ok;
  logic       pop_ok;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = slots_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_ok) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slots_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

### rtl/srsl_checker.sv
// ----------------------------------------------------------------------------
// srsl_checker: port-level checks for the sorted range-start lookup
// Watches the queue-style ports of the top level over time.
// ----------------------------------------------------------------------------
module srsl_checker import srsl_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    push,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result_o
);

  // Reset empties the result queue, so the cycle after
  // reset shows no result.
  assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result visible right after reset");

  // The intake queue only fills through a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // A result only leaves through a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result dropped without a pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed");

endmodule

bind sorted_range_start_lookup srsl_checker u_srsl_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .push    (push),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .result_o(result_o)
);
